// File: rtl/dfe_pkg.sv
// dfe_pkg: shared types, register indexes, fsm states and belief tables
// for the drowsiness evidence fusion block
// no dependencies
package dfe_pkg;

   // field widths
   localparam int MASS_W     = 16;
   localparam int RATIO_W    = 16;
   localparam int TIME_W     = 32;
   localparam int CLASS_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // product and product-sum widths of the fusion datapath
   localparam int PROD_W  = 2 * MASS_W;
   localparam int TOTAL_W = PROD_W + 2;

   typedef logic [MASS_W-1:0] mass_type;
   typedef mass_type belief_type [3];

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EYE_DANGER   = 3'd0,
      CSR_EYE_WARNING  = 3'd1,
      CSR_MOUTH_SPEAK  = 3'd2,
      CSR_MOUTH_YAWN   = 3'd3,
      CSR_DECISION     = 3'd4,
      CSR_LONG_CLOSURE = 3'd5,
      CSR_LONG_YAWN    = 3'd6
   } csr_idx_type;

   // reset values of the configuration registers
   localparam logic [CSR_DATA_W-1:0] EYE_DANGER_RST   = 16'd2621;
   localparam logic [CSR_DATA_W-1:0] EYE_WARNING_RST  = 16'd3604;
   localparam logic [CSR_DATA_W-1:0] MOUTH_SPEAK_RST  = 16'd8192;
   localparam logic [CSR_DATA_W-1:0] MOUTH_YAWN_RST   = 16'd12780;
   localparam logic [CSR_DATA_W-1:0] DECISION_RST     = 16'd26214;
   localparam logic [CSR_DATA_W-1:0] LONG_CLOSURE_RST = 16'd2000;
   localparam logic [CSR_DATA_W-1:0] LONG_YAWN_RST    = 16'd4000;

   // fatigue class codes
   typedef enum logic [CLASS_W-1:0] {
      CLASS_NO_FACE  = 3'd0,
      CLASS_FATIGUED = 3'd1,
      CLASS_MILD     = 3'd2,
      CLASS_SPEAKING = 3'd3,
      CLASS_ALERT    = 3'd4
   } class_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRACK,
      ST_MUL,
      ST_DSET,
      ST_DITER,
      ST_OUT
   } fsm_type;

   // belief group being fused
   typedef enum logic {
      GRP_MOUTH = 1'b0,
      GRP_EYE   = 1'b1
   } grp_type;

   // mouth beliefs: yawn, speak, closed (Q0.15)
   localparam belief_type MOUTH_CLOSED_BEL = '{16'd1638,  16'd1638,  16'd29491};
   localparam belief_type MOUTH_SPEAK_BEL  = '{16'd1638,  16'd29491, 16'd1638};
   localparam belief_type MOUTH_YAWN_BEL   = '{16'd29491, 16'd1638,  16'd1638};
   localparam belief_type MOUTH_LYAWN_BEL  = '{16'd32112, 16'd328,   16'd328};

   // eye beliefs: alert, mild, tired (Q0.15)
   localparam belief_type EYE_OPEN_BEL  = '{16'd29491, 16'd1638,  16'd1638};
   localparam belief_type EYE_MID_BEL   = '{16'd164,   16'd32440, 16'd164};
   localparam belief_type EYE_SHUT_BEL  = '{16'd1638,  16'd1638,  16'd29491};
   localparam belief_type EYE_LSHUT_BEL = '{16'd328,   16'd328,   16'd32112};

endpackage

// File: rtl/dfe_if.sv
// dfe channel interfaces: evaluation input, fused result and register write
// depends on dfe_pkg for field widths

// one evaluation per frame
interface dfe_req_if import dfe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               face_present;
   logic [RATIO_W-1:0] eye_ratio;
   logic [RATIO_W-1:0] mouth_ratio;
   logic [TIME_W-1:0]  time_ms;
   logic               clear_history;

   modport source (output valid, face_present, eye_ratio, mouth_ratio, time_ms,
                   clear_history, input ready);
   modport sink   (input valid, face_present, eye_ratio, mouth_ratio, time_ms,
                   clear_history, output ready);
endinterface

// fatigue class and fused masses
interface dfe_rsp_if import dfe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] fatigue_class;
   logic [MASS_W-1:0]  yawn_mass;
   logic [MASS_W-1:0]  speak_mass;
   logic [MASS_W-1:0]  closed_mouth_mass;
   logic [MASS_W-1:0]  alert_mass;
   logic [MASS_W-1:0]  mild_mass;
   logic [MASS_W-1:0]  tired_mass;

   modport source (output valid, fatigue_class, yawn_mass, speak_mass,
                   closed_mouth_mass, alert_mass, mild_mass, tired_mass,
                   input ready);
   modport sink   (input valid, fatigue_class, yawn_mass, speak_mass,
                   closed_mouth_mass, alert_mass, mild_mass, tired_mass,
                   output ready);
endinterface

// configuration register write
interface dfe_csr_if import dfe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/drowsiness_evidence_fusion.sv
// drowsiness_evidence_fusion: episode tracking, belief lookup and serial
// evidence fusion; depends on dfe_pkg and the dfe_if channel interfaces
//
// One evaluation transaction is taken at a time. A frame without a face, or
// one that starts a fresh history (after reset or a history clear), skips the
// fusion. A frame that fuses into a stored history uses one shared 16x16
// multiplier to form the three products of each group, then one restoring
// divider produces each of the six normalized masses one quotient bit per
// cycle; a zero product sum takes the current belief instead. The input is
// ready again the cycle after the result enters the output register; a
// finished result waits there without holding up the next transaction.
// Register writes are always accepted and should only be issued while idle.
module drowsiness_evidence_fusion
   import dfe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dfe_req_if.sink   req_ch,
   dfe_rsp_if.source rsp_ch,
   dfe_csr_if.sink   csr_ch
);

   // configuration registers
   logic [CSR_DATA_W-1:0] eye_danger_ff, eye_warning_ff, mouth_speak_ff, mouth_yawn_ff;
   logic [CSR_DATA_W-1:0] decision_ff, long_closure_ms_ff, long_yawn_ms_ff;

   // captured evaluation
   logic               face_ff, clear_ff;
   logic [RATIO_W-1:0] eye_ff, mouth_ff;
   logic [TIME_W-1:0]  time_ff;

   // episode and history state
   logic              eyes_shut_ff, long_closure_ff, yawn_active_ff, long_yawn_ff;
   logic              hist_valid_ff;
   logic [TIME_W-1:0] shut_start_ff, yawn_start_ff;
   belief_type        mouth_hist_ff, eye_hist_ff, mouth_cur_ff, eye_cur_ff;

   // fusion datapath
   logic [PROD_W-1:0]  prod_ff [3];
   logic [TOTAL_W-1:0] total_ff;
   logic [MASS_W-1:0]  quot_ff, numlo_ff;
   logic [TOTAL_W-1:0] rem_ff;
   grp_type            grp_ff;
   logic [1:0]         idx_ff;
   logic [3:0]         step_ff;

   // output register
   logic              rsp_valid_ff;
   logic [CLASS_W-1:0] class_ff;
   mass_type          out_mass_ff [6];

   fsm_type state_ff, state_in;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   logic req_take, out_free;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // ---------------------------------------------------------------------
   // episode tracking and band selection
   // ---------------------------------------------------------------------
   logic              eye_low, eye_high, mouth_low, mouth_high;
   logic              closure_end, yawn_end, closure_begin, yawn_begin;
   logic [TIME_W-1:0] closure_len, yawn_len;
   logic              long_closure_new, long_yawn_new, keep_hist;
   belief_type        mouth_bel, eye_bel;

   always_comb begin
      eye_low    = eye_ff < eye_danger_ff;
      eye_high   = eye_ff > eye_warning_ff;
      mouth_low  = mouth_ff < mouth_speak_ff;
      mouth_high = mouth_ff > mouth_yawn_ff;

      closure_begin = face_ff && eye_low && !eyes_shut_ff;
      closure_end   = face_ff && !eye_low && eyes_shut_ff;
      yawn_begin    = face_ff && mouth_high && !yawn_active_ff;
      yawn_end      = face_ff && !mouth_high && yawn_active_ff;

      closure_len = time_ff - shut_start_ff;
      yawn_len    = time_ff - yawn_start_ff;

      long_closure_new = closure_end
         ? (closure_len >= {{(TIME_W-CSR_DATA_W){1'b0}}, long_closure_ms_ff})
         : long_closure_ff;
      long_yawn_new = yawn_end
         ? (yawn_len >= {{(TIME_W-CSR_DATA_W){1'b0}}, long_yawn_ms_ff})
         : long_yawn_ff;

      if (mouth_low) begin
         mouth_bel = MOUTH_CLOSED_BEL;
      end else if (mouth_high) begin
         mouth_bel = long_yawn_new ? MOUTH_LYAWN_BEL : MOUTH_YAWN_BEL;
      end else begin
         mouth_bel = MOUTH_SPEAK_BEL;
      end

      if (eye_high) begin
         eye_bel = EYE_OPEN_BEL;
      end else if (eye_low) begin
         eye_bel = long_closure_new ? EYE_LSHUT_BEL : EYE_SHUT_BEL;
      end else begin
         eye_bel = EYE_MID_BEL;
      end

      keep_hist = hist_valid_ff && !clear_ff;
   end

   // ---------------------------------------------------------------------
   // shared multiplier and serial divider
   // ---------------------------------------------------------------------
   mass_type             mul_a, mul_b;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W+14:0]   numer;
   logic [TOTAL_W:0]     shifted, trial;
   logic                 fits, zero_total, last_step, last_idx;
   logic [MASS_W-1:0]    quot_next;

   always_comb begin
      mul_a = (grp_ff == GRP_EYE) ? eye_hist_ff[idx_ff] : mouth_hist_ff[idx_ff];
      mul_b = (grp_ff == GRP_EYE) ? eye_cur_ff[idx_ff] : mouth_cur_ff[idx_ff];
      prod  = mul_a * mul_b;

      // p * 2^15 + total / 2
      numer = {prod_ff[idx_ff], 15'd0}
            + {{(PROD_W+15-TOTAL_W+1){1'b0}}, total_ff[TOTAL_W-1:1]};

      shifted   = {rem_ff, numlo_ff[MASS_W-1]};
      trial     = shifted - {1'b0, total_ff};
      fits      = shifted >= {1'b0, total_ff};
      quot_next = {quot_ff[MASS_W-2:0], fits};

      zero_total = (total_ff == '0);
      last_step  = (step_ff == 4'd15);
      last_idx   = (idx_ff == 2'd2);
   end

   // ---------------------------------------------------------------------
   // decision on the final histories
   // ---------------------------------------------------------------------
   class_type cls;

   always_comb begin
      if (!face_ff) begin
         cls = CLASS_NO_FACE;
      end else if (mouth_hist_ff[0] > decision_ff || eye_hist_ff[2] > decision_ff) begin
         cls = CLASS_FATIGUED;
      end else if (eye_hist_ff[1] > decision_ff) begin
         cls = CLASS_MILD;
      end else if (mouth_hist_ff[1] > decision_ff) begin
         cls = CLASS_SPEAKING;
      end else begin
         cls = CLASS_ALERT;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_TRACK;
         end
         ST_TRACK: begin
            state_in = (face_ff && keep_hist) ? ST_MUL : ST_OUT;
         end
         ST_MUL: begin
            if (last_idx) state_in = ST_DSET;
         end
         ST_DSET: begin
            if (zero_total) begin
               state_in = (grp_ff == GRP_MOUTH) ? ST_MUL : ST_OUT;
            end else begin
               state_in = ST_DITER;
            end
         end
         ST_DITER: begin
            if (last_step) begin
               if (!last_idx) begin
                  state_in = ST_DSET;
               end else begin
                  state_in = (grp_ff == GRP_MOUTH) ? ST_MUL : ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         eye_danger_ff      <= EYE_DANGER_RST;
         eye_warning_ff     <= EYE_WARNING_RST;
         mouth_speak_ff     <= MOUTH_SPEAK_RST;
         mouth_yawn_ff      <= MOUTH_YAWN_RST;
         decision_ff        <= DECISION_RST;
         long_closure_ms_ff <= LONG_CLOSURE_RST;
         long_yawn_ms_ff    <= LONG_YAWN_RST;
      end else if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_EYE_DANGER:   eye_danger_ff      <= csr_ch.data;
            CSR_EYE_WARNING:  eye_warning_ff     <= csr_ch.data;
            CSR_MOUTH_SPEAK:  mouth_speak_ff     <= csr_ch.data;
            CSR_MOUTH_YAWN:   mouth_yawn_ff      <= csr_ch.data;
            CSR_DECISION:     decision_ff        <= csr_ch.data;
            CSR_LONG_CLOSURE: long_closure_ms_ff <= csr_ch.data;
            CSR_LONG_YAWN:    long_yawn_ms_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // input capture
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         face_ff  <= req_ch.face_present;
         eye_ff   <= req_ch.eye_ratio;
         mouth_ff <= req_ch.mouth_ratio;
         time_ff  <= req_ch.time_ms;
         clear_ff <= req_ch.clear_history;
      end
   end

   // ---------------------------------------------------------------------
   // episode state, histories and fusion datapath
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         eyes_shut_ff    <= 1'b0;
         long_closure_ff <= 1'b0;
         yawn_active_ff  <= 1'b0;
         long_yawn_ff    <= 1'b0;
         shut_start_ff   <= '0;
         yawn_start_ff   <= '0;
         hist_valid_ff   <= 1'b0;
         mouth_hist_ff   <= '{default: '0};
         eye_hist_ff     <= '{default: '0};
         grp_ff          <= GRP_MOUTH;
         idx_ff          <= '0;
         step_ff         <= '0;
      end else begin
         case (state_ff)
            // track episodes, pick beliefs, clear or seed the histories
            ST_TRACK: begin
               if (closure_begin) begin
                  eyes_shut_ff  <= 1'b1;
                  shut_start_ff <= time_ff;
               end else if (closure_end) begin
                  eyes_shut_ff <= 1'b0;
               end
               if (yawn_begin) begin
                  yawn_active_ff <= 1'b1;
                  yawn_start_ff  <= time_ff;
               end else if (yawn_end) begin
                  yawn_active_ff <= 1'b0;
               end
               long_closure_ff <= long_closure_new;
               long_yawn_ff    <= long_yawn_new;
               mouth_cur_ff    <= mouth_bel;
               eye_cur_ff      <= eye_bel;
               grp_ff          <= GRP_MOUTH;
               idx_ff          <= '0;
               if (face_ff) begin
                  if (!keep_hist) begin
                     mouth_hist_ff <= mouth_bel;
                     eye_hist_ff   <= eye_bel;
                     hist_valid_ff <= 1'b1;
                  end
               end else if (clear_ff) begin
                  mouth_hist_ff <= '{default: '0};
                  eye_hist_ff   <= '{default: '0};
                  hist_valid_ff <= 1'b0;
               end
            end
            // one product per cycle, summed as it goes
            ST_MUL: begin
               prod_ff[idx_ff] <= prod;
               total_ff <= ((idx_ff == 2'd0) ? '0 : total_ff)
                         + {{(TOTAL_W-PROD_W){1'b0}}, prod};
               idx_ff <= last_idx ? 2'd0 : idx_ff + 2'd1;
            end
            // load the divider, or fall back to the current belief
            ST_DSET: begin
               if (zero_total) begin
                  if (grp_ff == GRP_EYE) begin
                     eye_hist_ff <= eye_cur_ff;
                  end else begin
                     mouth_hist_ff <= mouth_cur_ff;
                  end
                  grp_ff <= GRP_EYE;
                  idx_ff <= '0;
               end else begin
                  rem_ff   <= {{(TOTAL_W-(PROD_W-1)){1'b0}}, numer[PROD_W+14:MASS_W]};
                  numlo_ff <= numer[MASS_W-1:0];
                  quot_ff  <= '0;
                  step_ff  <= '0;
               end
            end
            // restoring division, one quotient bit per cycle
            ST_DITER: begin
               rem_ff   <= fits ? trial[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
               numlo_ff <= {numlo_ff[MASS_W-2:0], 1'b0};
               quot_ff  <= quot_next;
               step_ff  <= step_ff + 4'd1;
               if (last_step) begin
                  if (grp_ff == GRP_EYE) begin
                     eye_hist_ff[idx_ff] <= quot_next;
                  end else begin
                     mouth_hist_ff[idx_ff] <= quot_next;
                  end
                  if (last_idx) begin
                     grp_ff <= GRP_EYE;
                     idx_ff <= '0;
                  end else begin
                     idx_ff <= idx_ff + 2'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         class_ff       <= cls;
         out_mass_ff[0] <= mouth_hist_ff[0];
         out_mass_ff[1] <= mouth_hist_ff[1];
         out_mass_ff[2] <= mouth_hist_ff[2];
         out_mass_ff[3] <= eye_hist_ff[0];
         out_mass_ff[4] <= eye_hist_ff[1];
         out_mass_ff[5] <= eye_hist_ff[2];
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.fatigue_class     = class_ff;
   assign rsp_ch.yawn_mass         = out_mass_ff[0];
   assign rsp_ch.speak_mass        = out_mass_ff[1];
   assign rsp_ch.closed_mouth_mass = out_mass_ff[2];
   assign rsp_ch.alert_mass        = out_mass_ff[3];
   assign rsp_ch.mild_mass         = out_mass_ff[4];
   assign rsp_ch.tired_mass        = out_mass_ff[5];

endmodule

// File: tb/drowsiness_evidence_fusion_tb.sv
`timescale 1ns / 1ps
// drowsiness_evidence_fusion_tb: self-checking bench for the evidence fusion block
// predicts episode tracking, belief lookup and normalized fusion per frame and scores
// every fused result; depends on dfe_pkg, the dfe_if interfaces and the block itself
module drowsiness_evidence_fusion_tb
   import dfe_pkg::*;
();

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 150;
   localparam int unsigned REPORT_CAP     = 40;

   // register values after reset
   localparam logic [15:0] DEF_EYE_DANGER   = 16'd2621;
   localparam logic [15:0] DEF_EYE_WARNING  = 16'd3604;
   localparam logic [15:0] DEF_MOUTH_SPEAK  = 16'd8192;
   localparam logic [15:0] DEF_MOUTH_YAWN   = 16'd12780;
   localparam logic [15:0] DEF_DECISION     = 16'd26214;
   localparam logic [15:0] DEF_LONG_CLOSURE = 16'd2000;
   localparam logic [15:0] DEF_LONG_YAWN    = 16'd4000;

   // three masses, element 0 in the low bits
   typedef logic [2:0][15:0] triple_type;

   // mouth beliefs packed as {closed, speak, yawn}
   localparam triple_type MB_CLOSED    = {16'd29491, 16'd1638,  16'd1638};
   localparam triple_type MB_SPEAK     = {16'd1638,  16'd29491, 16'd1638};
   localparam triple_type MB_YAWN      = {16'd1638,  16'd1638,  16'd29491};
   localparam triple_type MB_LONG_YAWN = {16'd328,   16'd328,   16'd32112};
   // eye beliefs packed as {tired, mild, alert}
   localparam triple_type EB_OPEN      = {16'd1638,  16'd1638,  16'd29491};
   localparam triple_type EB_MID       = {16'd164,   16'd32440, 16'd164};
   localparam triple_type EB_SHUT      = {16'd29491, 16'd1638,  16'd1638};
   localparam triple_type EB_LONG_SHUT = {16'd32112, 16'd328,   16'd328};

   typedef struct packed {
      logic        face;
      logic [15:0] eye;
      logic [15:0] mouth;
      logic [31:0] stamp;
      logic        clr;
   } frame_type;

   typedef struct packed {
      class_type   cls;
      logic [15:0] yawn;
      logic [15:0] speak;
      logic [15:0] closed;
      logic [15:0] alert;
      logic [15:0] mild;
      logic [15:0] tired;
   } fused_result_type;

   logic clock;
   logic reset;

   dfe_req_if req_ch ();
   dfe_rsp_if rsp_ch ();
   dfe_csr_if csr_ch ();

   drowsiness_evidence_fusion DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor copy of the registers
   logic [15:0] cfg_eye_danger   = DEF_EYE_DANGER;
   logic [15:0] cfg_eye_warning  = DEF_EYE_WARNING;
   logic [15:0] cfg_mouth_speak  = DEF_MOUTH_SPEAK;
   logic [15:0] cfg_mouth_yawn   = DEF_MOUTH_YAWN;
   logic [15:0] cfg_decision     = DEF_DECISION;
   logic [15:0] cfg_long_closure = DEF_LONG_CLOSURE;
   logic [15:0] cfg_long_yawn    = DEF_LONG_YAWN;

   // predictor copy of the episode trackers and fused histories
   logic        eyes_shut    = 1'b0;
   logic [31:0] shut_start   = '0;
   logic        long_closure = 1'b0;
   logic        yawn_active  = 1'b0;
   logic [31:0] yawn_start   = '0;
   logic        long_yawn    = 1'b0;
   logic        hist_valid   = 1'b0;
   triple_type  mouth_hist   = '0;
   triple_type  eye_hist     = '0;

   fused_result_type expected_fusion_q [$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned results_checked = 0;
   int unsigned frames_sent = 0;
   int unsigned faces_sent = 0;
   int unsigned clears_sent = 0;
   int unsigned reg_writes = 0;
   int unsigned long_closures = 0;
   int unsigned long_yawns = 0;
   int unsigned quiet_cycles = 0;
   int unsigned class_seen [5] = '{default: 0};

   // random frame generator state
   logic [31:0] now_ms = '0;
   int unsigned eye_band = 0;
   int unsigned mouth_band = 0;
   int unsigned eye_hold = 0;
   int unsigned mouth_hold = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // normalized element-wise product of history and current belief
   function automatic triple_type normalize_product(input triple_type hist,
                                                    input triple_type cur);
      logic [63:0] prod [3];
      logic [63:0] total;
      triple_type  fused;
      total = '0;
      for (int i = 0; i < 3; i++) begin
         prod[i] = 64'(hist[i]) * 64'(cur[i]);
         total   = total + prod[i];
      end
      if (total == 0)
         return cur;
      for (int i = 0; i < 3; i++)
         fused[i] = 16'((prod[i] * 64'd32768 + total / 2) / total);
      return fused;
   endfunction

   // advance the predictor by one accepted frame and queue its result
   task automatic fuse_evidence(input frame_type fr);
      triple_type       mb;
      triple_type       eb;
      fused_result_type r;
      logic [31:0]      span;
      if (fr.clr) begin
         hist_valid = 1'b0;
         mouth_hist = '0;
         eye_hist   = '0;
      end
      r.cls = CLASS_NO_FACE;
      if (fr.face) begin
         // eye closure episode
         if (fr.eye < cfg_eye_danger && !eyes_shut) begin
            shut_start = fr.stamp;
            eyes_shut  = 1'b1;
         end else if (fr.eye >= cfg_eye_danger && eyes_shut) begin
            span         = fr.stamp - shut_start;
            long_closure = (span >= {16'd0, cfg_long_closure});
            eyes_shut    = 1'b0;
            if (long_closure) long_closures++;
         end
         // yawn episode
         if (fr.mouth > cfg_mouth_yawn && !yawn_active) begin
            yawn_start  = fr.stamp;
            yawn_active = 1'b1;
         end else if (fr.mouth <= cfg_mouth_yawn && yawn_active) begin
            span        = fr.stamp - yawn_start;
            long_yawn   = (span >= {16'd0, cfg_long_yawn});
            yawn_active = 1'b0;
            if (long_yawn) long_yawns++;
         end
         // band lookup, tested in priority order
         if (fr.mouth < cfg_mouth_speak)     mb = MB_CLOSED;
         else if (fr.mouth > cfg_mouth_yawn) mb = long_yawn ? MB_LONG_YAWN : MB_YAWN;
         else                                mb = MB_SPEAK;
         if (fr.eye > cfg_eye_warning)       eb = EB_OPEN;
         else if (fr.eye < cfg_eye_danger)   eb = long_closure ? EB_LONG_SHUT : EB_SHUT;
         else                                eb = EB_MID;
         // seed or fuse
         if (!hist_valid) begin
            mouth_hist = mb;
            eye_hist   = eb;
            hist_valid = 1'b1;
         end else begin
            mouth_hist = normalize_product(mouth_hist, mb);
            eye_hist   = normalize_product(eye_hist, eb);
         end
         // class decision
         if (mouth_hist[0] > cfg_decision || eye_hist[2] > cfg_decision)
            r.cls = CLASS_FATIGUED;
         else if (eye_hist[1] > cfg_decision)
            r.cls = CLASS_MILD;
         else if (mouth_hist[1] > cfg_decision)
            r.cls = CLASS_SPEAKING;
         else
            r.cls = CLASS_ALERT;
      end
      r.yawn   = mouth_hist[0];
      r.speak  = mouth_hist[1];
      r.closed = mouth_hist[2];
      r.alert  = eye_hist[0];
      r.mild   = eye_hist[1];
      r.tired  = eye_hist[2];
      expected_fusion_q.insert(expected_fusion_q.size(), r);
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_CAP)
         $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   results_checked, name, got, want));
   endtask

   // result side: random stalls
   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   // score each fused result against the oldest prediction
   always @(posedge clock) begin : check_results
      fused_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_fusion_q.size() == 0) begin
            report_mismatch("fused result with no frame pending");
         end else begin
            want = expected_fusion_q.pop_front();
            check_field("fatigue_class", 16'(rsp_ch.fatigue_class), 16'(want.cls));
            check_field("yawn_mass", rsp_ch.yawn_mass, want.yawn);
            check_field("speak_mass", rsp_ch.speak_mass, want.speak);
            check_field("closed_mouth_mass", rsp_ch.closed_mouth_mass, want.closed);
            check_field("alert_mass", rsp_ch.alert_mass, want.alert);
            check_field("mild_mass", rsp_ch.mild_mass, want.mild);
            check_field("tired_mass", rsp_ch.tired_mass, want.tired);
            if (rsp_ch.fatigue_class <= CLASS_ALERT)
               class_seen[rsp_ch.fatigue_class]++;
            results_checked++;
         end
      end
   end

   // watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_fusion_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one evaluation transaction, with random idle cycles ahead of it
   task automatic send_frame(input frame_type fr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.face_present  <= fr.face;
      req_ch.eye_ratio     <= fr.eye;
      req_ch.mouth_ratio   <= fr.mouth;
      req_ch.time_ms       <= fr.stamp;
      req_ch.clear_history <= fr.clr;
      do @(posedge clock); while (!req_ch.ready);
      fuse_evidence(fr);
      frames_sent++;
      if (fr.face) faces_sent++;
      if (fr.clr) clears_sent++;
   endtask

   // one register write transaction; valid is lowered by the caller
   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_EYE_DANGER:   cfg_eye_danger   = val;
         CSR_EYE_WARNING:  cfg_eye_warning  = val;
         CSR_MOUTH_SPEAK:  cfg_mouth_speak  = val;
         CSR_MOUTH_YAWN:   cfg_mouth_yawn   = val;
         CSR_DECISION:     cfg_decision     = val;
         CSR_LONG_CLOSURE: cfg_long_closure = val;
         CSR_LONG_YAWN:    cfg_long_yawn    = val;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic load_config(input logic [15:0] danger, warning, speak, yawn, decision,
                              closure_ms, yawn_ms);
      write_reg(CSR_EYE_DANGER, danger);
      write_reg(CSR_EYE_WARNING, warning);
      write_reg(CSR_MOUTH_SPEAK, speak);
      write_reg(CSR_MOUTH_YAWN, yawn);
      write_reg(CSR_DECISION, decision);
      write_reg(CSR_LONG_CLOSURE, closure_ms);
      write_reg(CSR_LONG_YAWN, yawn_ms);
      csr_ch.valid <= 1'b0;
   endtask

   // stop sending and wait until every predicted result has been scored
   task automatic wait_fusions_done();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_fusion_q.size() != 0);
   endtask

   function automatic frame_type mk_frame(input logic face, input logic [15:0] eye, mouth,
                                          input logic [31:0] stamp, input logic clr);
      frame_type fr;
      fr.face  = face;
      fr.eye   = eye;
      fr.mouth = mouth;
      fr.stamp = stamp;
      fr.clr   = clr;
      return fr;
   endfunction

   // ratio in band 0 (below lo), 1 (between), 2 (above hi), with boundary hits and noise
   function automatic logic [15:0] band_ratio(input logic [15:0] lo, hi,
                                              input int unsigned band);
      int unsigned sel;
      sel = $urandom_range(19);
      if (sel == 0) return 16'($urandom);
      if (sel == 1) return lo;
      if (sel == 2) return hi;
      if (sel == 3) return lo - 16'd1;
      if (sel == 4) return hi + 16'd1;
      case (band)
         0:       return (lo == 0) ? 16'd0 : 16'($urandom_range(lo - 1, 0));
         1:       return (lo <= hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
         default: return (hi == 16'hFFFF) ? hi : 16'($urandom_range(16'hFFFF, hi + 1));
      endcase
   endfunction

   // frames hold each band for a stretch so episodes of every length form
   function automatic frame_type random_frame();
      frame_type   fr;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3) now_ms = $urandom;
      else          now_ms = now_ms + $urandom_range(300, 5);
      if (eye_hold == 0) begin
         eye_band = $urandom_range(2);
         eye_hold = $urandom_range(30, 1);
      end
      if (mouth_hold == 0) begin
         mouth_band = $urandom_range(2);
         mouth_hold = $urandom_range(40, 1);
      end
      eye_hold--;
      mouth_hold--;
      fr.face  = ($urandom_range(99) >= 6);
      fr.clr   = ($urandom_range(99) < 2);
      fr.stamp = now_ms;
      fr.eye   = band_ratio(cfg_eye_danger, cfg_eye_warning, eye_band);
      fr.mouth = band_ratio(cfg_mouth_speak, cfg_mouth_yawn, mouth_band);
      // occasional frame with no structure at all
      if (roll >= 95) begin
         fr.face  = 1'($urandom);
         fr.clr   = 1'($urandom);
         fr.eye   = 16'($urandom);
         fr.mouth = 16'($urandom);
         fr.stamp = $urandom;
      end
      return fr;
   endfunction

   task automatic load_random_config(input int unsigned kind);
      case (kind)
         0: load_config(DEF_EYE_DANGER, DEF_EYE_WARNING, DEF_MOUTH_SPEAK, DEF_MOUTH_YAWN,
                        DEF_DECISION, DEF_LONG_CLOSURE, DEF_LONG_YAWN);
         // short episodes mark long often
         1: load_config(DEF_EYE_DANGER, DEF_EYE_WARNING, DEF_MOUTH_SPEAK, DEF_MOUTH_YAWN,
                        16'($urandom_range(32768, 16384)), 16'($urandom_range(600)),
                        16'($urandom_range(1200)));
         // arbitrary levels, crossed ones included
         2: load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom_range(3000)), 16'($urandom_range(6000)));
         // every register at an end of its range, the decision level also at full scale
         default: load_config($urandom_range(1) ? 16'hFFFF : 16'd0,
                              $urandom_range(1) ? 16'hFFFF : 16'd0,
                              $urandom_range(1) ? 16'hFFFF : 16'd0,
                              $urandom_range(1) ? 16'hFFFF : 16'd0,
                              $urandom_range(1) ? 16'd32768 : ($urandom_range(1) ? 16'hFFFF
                                                                                : 16'd0),
                              $urandom_range(1) ? 16'hFFFF : 16'd0,
                              $urandom_range(1) ? 16'hFFFF : 16'd0);
      endcase
   endtask

   // closure and yawn episodes at the default levels, boundaries and timestamp wrap
   task automatic test_episode_tracking();
      send_frame(mk_frame(1'b0, 16'd0, 16'd0, 32'd1000, 1'b0));
      send_frame(mk_frame(1'b1, 16'd5000, 16'd0, 32'd1033, 1'b0));
      // ratios equal to a level fall in the middle band
      send_frame(mk_frame(1'b1, DEF_EYE_WARNING, DEF_MOUTH_SPEAK, 32'd1066, 1'b0));
      send_frame(mk_frame(1'b1, DEF_EYE_DANGER, DEF_MOUTH_YAWN, 32'd1080, 1'b0));
      // closure and yawn both open at 1100
      send_frame(mk_frame(1'b1, DEF_EYE_DANGER - 16'd1, DEF_MOUTH_YAWN + 16'd1,
                          32'd1100, 1'b0));
      send_frame(mk_frame(1'b1, 16'd0, 16'hFFFF, 32'd2600, 1'b0));
      // closure of exactly the long length
      send_frame(mk_frame(1'b1, 16'hFFFF, 16'hFFFF, 32'd3100, 1'b0));
      // yawn one ms short of long, new closure opens
      send_frame(mk_frame(1'b1, 16'd0, 16'd0, 32'd5099, 1'b0));
      send_frame(mk_frame(1'b1, 16'd0, 16'hFFFF, 32'd5200, 1'b0));
      send_frame(mk_frame(1'b1, 16'd3000, 16'hFFFF, 32'd9200, 1'b0));
      // yawn of exactly the long length
      send_frame(mk_frame(1'b1, 16'd3000, 16'd9000, 32'd9200, 1'b0));
      // long flags pick the strongest beliefs
      send_frame(mk_frame(1'b1, 16'd100, 16'd20000, 32'd9300, 1'b0));
      // episodes spanning the timestamp wrap
      send_frame(mk_frame(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FC00, 1'b0));
      send_frame(mk_frame(1'b1, 16'd0, 16'hFFFF, 32'hFFFF_FE00, 1'b0));
      send_frame(mk_frame(1'b1, 16'd5000, 16'd0, 32'h0000_0600, 1'b0));
   endtask

   // frames without a face and history clears
   task automatic test_face_and_clear();
      send_frame(mk_frame(1'b0, 16'd0, 16'hFFFF, 32'd2000, 1'b0));
      send_frame(mk_frame(1'b0, 16'd0, 16'd0, 32'd2100, 1'b1));
      send_frame(mk_frame(1'b1, 16'd3000, 16'd10000, 32'd2200, 1'b0));
      send_frame(mk_frame(1'b1, 16'd0, 16'd0, 32'd2300, 1'b1));
   endtask

   // levels at their ends, crossed levels, decision level above full scale
   task automatic test_register_extremes();
      wait_fusions_done();
      load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_frame(mk_frame(1'b1, 16'd0, 16'd0, 32'd3000, 1'b1));
      send_frame(mk_frame(1'b1, 16'hFFFF, 16'hFFFF, 32'd3001, 1'b0));
      wait_fusions_done();
      load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32768, 16'hFFFF, 16'hFFFF);
      send_frame(mk_frame(1'b1, 16'hFFFF, 16'hFFFF, 32'd3002, 1'b1));
      send_frame(mk_frame(1'b1, 16'd0, 16'd0, 32'd3003, 1'b0));
      wait_fusions_done();
      load_config(16'd30000, 16'd1000, 16'd20000, 16'd5000, 16'hFFFF, 16'd0, 16'd0);
      send_frame(mk_frame(1'b1, 16'd2000, 16'd10000, 32'd3004, 1'b1));
      send_frame(mk_frame(1'b1, 16'd500, 16'd3000, 32'd3005, 1'b0));
   endtask

   // random frame stretches, each under a fresh register setting
   task automatic test_random_frames(input int unsigned chunks, input int unsigned per_chunk);
      for (int unsigned c = 0; c < chunks; c++) begin
         wait_fusions_done();
         load_random_config(c % 4);
         for (int unsigned n = 0; n < per_chunk; n++)
            send_frame(random_frame());
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.face_present  = 1'b0;
      req_ch.eye_ratio     = '0;
      req_ch.mouth_ratio   = '0;
      req_ch.time_ms       = '0;
      req_ch.clear_history = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_EYE_DANGER;
      csr_ch.data          = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct  = 28;
      recv_stall_pct = 81;
      test_episode_tracking();
      test_face_and_clear();
      test_register_extremes();
      test_random_frames(4, 140);
      // sender mostly idle, receiver mostly ready
      send_idle_pct  = 81;
      recv_stall_pct = 28;
      test_random_frames(4, 140);
      // back to back
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_frames(4, 140);

      wait_fusions_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_fusion_q.size() != 0)
         report_mismatch($sformatf("%0d fused results never arrived",
                                   expected_fusion_q.size()));

      $display("covered %0d frames (%0d with a face, %0d history clears), %0d register writes",
               frames_sent, faces_sent, clears_sent, reg_writes);
      $display("%0d results scored: class counts %0d/%0d/%0d/%0d/%0d",
               results_checked, class_seen[0], class_seen[1], class_seen[2], class_seen[3],
               class_seen[4]);
      $display("long closures %0d, long yawns %0d", long_closures, long_yawns);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
